>>> rtl/core/str_pkg.sv
// Shared types, field widths and lookup tables for the shaped tile rasterizer.
// No dependencies; compiled first.
`default_nettype none

package str_pkg;

   localparam int COORD_W  = 13;   // signed tile origin, raw register width
   localparam int PIX_W    = 12;   // emitted pixel coordinate
   localparam int ADDR_W   = 24;   // frame buffer address
   localparam int COLOR_W  = 32;
   localparam int SHAPE_W  = 4;
   localparam int TURN_W   = 2;
   localparam int WALL_W   = 6;
   localparam int CELLS    = 16;   // 4x4 tile
   localparam int CELL_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [COLOR_W-1:0] WALL_COLOR = 32'hFFFF_FFFF;

   // wall flag bits
   localparam int WALL_WEST  = 0;
   localparam int WALL_NORTH = 1;
   localparam int WALL_EAST  = 2;
   localparam int WALL_SOUTH = 3;
   localparam int WALL_NESW  = 4;
   localparam int WALL_NWSE  = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COL_LIMIT   = 2'd0,
      CSR_ROW_LIMIT   = 2'd1,
      CSR_ROW_STRIDE  = 2'd2
   } csr_index_type;

   // rotation permutation, one row per quarter turn
   localparam logic [CELL_W-1:0] PERM_TAB [4][CELLS] = '{
      '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
      '{12,  8,  4,  0, 13,  9,  5,  1, 14, 10,  6,  2, 15, 11,  7,  3},
      '{15, 14, 13, 12, 11, 10,  9,  8,  7,  6,  5,  4,  3,  2,  1,  0},
      '{ 3,  7, 11, 15,  2,  6, 10, 14,  1,  5,  9, 13,  0,  4,  8, 12}
   };

   // bit k of entry s is cell k of shape s
   localparam logic [CELLS-1:0] SHAPE_TAB [CELLS] = '{
      16'h0000, 16'hFFFF, 16'hF731, 16'h1133, 16'h88CC, 16'hFFEE, 16'hFF77, 16'h3333,
      16'h3100, 16'hCEFF, 16'h113F, 16'hEEC0, 16'hF600, 16'h0000, 16'h0000, 16'h0000
   };

   // live (already capped) configuration
   typedef struct packed {
      logic [COORD_W-1:0] col_limit;
      logic [COORD_W-1:0] row_limit;
      logic [COORD_W-1:0] row_stride;
   } cfg_type;

   // classified tile, handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COLOR_W-1:0] back_color;
      logic [COLOR_W-1:0] fore_color;
      logic [CELLS-1:0]   emit_mask;   // cells that produce a pixel
      logic [CELLS-1:0]   wall_mask;   // cells painted white
      logic [CELLS-1:0]   fore_mask;   // cells taking the foreground
   } tile_desc_type;

endpackage

`default_nettype wire

>>> rtl/core/str_channels.sv
// Valid/ready channel interfaces: tile requests, pixel responses, CSR writes.
// Depends on str_pkg.
`default_nettype none

interface str_req_if;
   import str_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [COORD_W-1:0]   origin_x;
   logic signed [COORD_W-1:0]   origin_y;
   logic [COLOR_W-1:0]          back_color;
   logic [COLOR_W-1:0]          fore_color;
   logic [SHAPE_W-1:0]          shape_code;
   logic [TURN_W-1:0]           turn;
   logic [WALL_W-1:0]           wall_flags;

   modport source (output valid, origin_x, origin_y, back_color, fore_color,
                   shape_code, turn, wall_flags, input ready);
   modport sink   (input valid, origin_x, origin_y, back_color, fore_color,
                   shape_code, turn, wall_flags, output ready);
endinterface

interface str_rsp_if;
   import str_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIX_W-1:0]     pixel_x;
   logic [PIX_W-1:0]     pixel_y;
   logic [ADDR_W-1:0]    pixel_address;
   logic [COLOR_W-1:0]   pixel_color;
   logic                 last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                   last_pixel, output ready);
endinterface

interface str_csr_if;
   import str_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [COORD_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/shaped_tile_rasterizer.sv
// Top level of the shaped tile rasterizer: CSR block, classifier, queue, emitter.
// Depends on str_pkg, str_channels, str_front, str_queue and str_back.
`default_nettype none

// Each accepted tile (4x4 cells) turns into zero to sixteen pixel writes on the
// rsp channel, in row-major order, with last_pixel marking the final one. The
// classifier decides every cell of a tile in the cycle of the req transfer, so
// req takes one tile per cycle while the two-entry queue has room; tiles that
// write nothing (both colors zero, fully clipped, or foreground-only with an
// empty mask and no walls) are consumed there and never reach the emitter. The
// emitter puts out one pixel per cycle while the rsp channel is ready; that
// single pixel port sets the sustained rate. The first pixel of a tile passes
// the queue, the current-tile register, the coordinate stage, the stride
// multiply and the output register. Clip width, clip height and row
// stride are written over the csr channel, always ready, and are clamped to
// MAX_DIM when written; change them only while no tile is in flight.
module shaped_tile_rasterizer #(
   parameter int MAX_DIM = 4096
) (
   input  logic     clock,
   input  logic     reset,
   str_req_if.sink  req_chan,
   str_rsp_if.source rsp_chan,
   str_csr_if.sink  csr_chan
);
   import str_pkg::*;

   localparam logic [16:0]        MaxDimW  = 17'(MAX_DIM);
   localparam logic [COORD_W-1:0] CfgReset = (MAX_DIM < 4096) ? COORD_W'(MAX_DIM)
                                                              : COORD_W'(4096);

   cfg_type              cfg_ff, cfg_in;
   logic [COORD_W-1:0]   csr_capped;
   logic                 csr_write;

   logic                 push_valid;
   logic                 push_ready;
   tile_desc_type        push_desc;
   logic                 pop_valid;
   logic                 pop_ready;
   tile_desc_type        pop_desc;

   // CSR block: clamp on write so the datapath only ever sees legal values
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;
   assign csr_capped     = ({4'b0, csr_chan.data} > MaxDimW) ? MaxDimW[COORD_W-1:0]
                                                             : csr_chan.data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_chan.index)
            CSR_COL_LIMIT:   cfg_in.col_limit   = csr_capped;
            CSR_ROW_LIMIT:   cfg_in.row_limit   = csr_capped;
            CSR_ROW_STRIDE:  cfg_in.row_stride  = csr_capped;
            default:         cfg_in = cfg_ff;   // unmapped index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.col_limit   <= CfgReset;
         cfg_ff.row_limit   <= CfgReset;
         cfg_ff.row_stride  <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   str_front u_front (
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   str_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   str_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTH
   a_cfg_clamped: assert property (@(posedge clock) disable iff (reset)
      {4'b0, cfg_ff.col_limit} <= MaxDimW && {4'b0, cfg_ff.row_stride} <= MaxDimW)
      else $error("configuration above MAX_DIM");

   a_cfg_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_chan.index == CSR_ROW_STRIDE |=> cfg_ff.row_stride == $past(csr_capped))
      else $error("row stride write lost");
`endif

endmodule

`default_nettype wire

>>> rtl/core/str_front.sv
// Tile classifier: shape lookup, walls, fill rules and clipping per cell.
// Depends on str_pkg and str_channels.
`default_nettype none

module str_front (
   str_req_if.sink                 req_chan,
   input  str_pkg::cfg_type        cfg,
   output logic                    push_valid,
   input  logic                    push_ready,
   output str_pkg::tile_desc_type  push_desc
);
   import str_pkg::*;

   logic                 fore_zero;
   logic                 back_zero;
   logic [CELLS-1:0]     emit_mask;
   logic [CELLS-1:0]     wall_mask;
   logic [CELLS-1:0]     fore_mask;
   logic [3:0]           col_ok;
   logic [3:0]           row_ok;
   logic [COORD_W:0]     px [4];
   logic [COORD_W:0]     py [4];

   assign fore_zero = (req_chan.fore_color == '0);
   assign back_zero = (req_chan.back_color == '0);

   // clip test per column and per row; sign bit set means left/above the frame
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         px[i] = {req_chan.origin_x[COORD_W-1], req_chan.origin_x} + (COORD_W+1)'(i);
         py[i] = {req_chan.origin_y[COORD_W-1], req_chan.origin_y} + (COORD_W+1)'(i);
         col_ok[i] = !px[i][COORD_W] && (px[i][COORD_W-1:0] < cfg.col_limit);
         row_ok[i] = !py[i][COORD_W] && (py[i][COORD_W-1:0] < cfg.row_limit);
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            logic shape_bit;
            logic wall;
            logic fill;
            shape_bit = SHAPE_TAB[req_chan.shape_code][PERM_TAB[req_chan.turn][4*r+c]];
            wall = (req_chan.wall_flags[WALL_WEST]  && c == 0)
                || (req_chan.wall_flags[WALL_NORTH] && r == 0)
                || (req_chan.wall_flags[WALL_EAST]  && c == 3)
                || (req_chan.wall_flags[WALL_SOUTH] && r == 3)
                || (req_chan.wall_flags[WALL_NESW]  && c == 3 - r)
                || (req_chan.wall_flags[WALL_NWSE]  && c == r);
            fill = fore_zero || !back_zero || shape_bit;
            wall_mask[4*r+c] = wall;
            fore_mask[4*r+c] = shape_bit && !fore_zero;
            // both colors zero suppresses walls as well
            emit_mask[4*r+c] = !(fore_zero && back_zero) && (wall || fill)
                               && col_ok[c] && row_ok[r];
         end
      end
   end

   // tiles with nothing to emit are consumed here and never queued
   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid && (emit_mask != '0);

   assign push_desc.origin_x   = req_chan.origin_x;
   assign push_desc.origin_y   = req_chan.origin_y;
   assign push_desc.back_color = req_chan.back_color;
   assign push_desc.fore_color = req_chan.fore_color;
   assign push_desc.emit_mask  = emit_mask;
   assign push_desc.wall_mask  = wall_mask;
   assign push_desc.fore_mask  = fore_mask;

endmodule

`default_nettype wire

>>> rtl/core/str_queue.sv
// Two-entry descriptor queue between the classifier and the pixel emitter.
// Depends on str_pkg.
`default_nettype none

module str_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  str_pkg::tile_desc_type  push_desc,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output str_pkg::tile_desc_type  pop_desc
);
   import str_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   tile_desc_type            entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]            count_ff, count_in;
   logic                     push;
   logic                     pop;

   assign push_ready = (count_ff != (PtrW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_desc   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrW+1)'(push) - (PtrW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PtrW+1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

>>> rtl/core/str_back.sv
// Pixel emitter: walks a tile's emit mask, one pixel per cycle if not stalled,
// computes the address via a registered multiply, drives the response register.
// Depends on str_pkg and str_channels.
`default_nettype none

module str_back (
   input  logic                    clock,
   input  logic                    reset,
   input  str_pkg::cfg_type        cfg,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  str_pkg::tile_desc_type  pop_desc,
   str_rsp_if.source               rsp_chan
);
   import str_pkg::*;

   // current tile
   tile_desc_type        desc_ff;
   logic                 cur_valid_ff, cur_valid_in;
   logic [CELLS-1:0]     left_ff, left_in;
   logic [CELL_W-1:0]    cur_cell;
   logic [CELLS-1:0]     cell_bit;
   logic                 tile_done;
   logic                 advance;
   logic                 load;

   // stage 1: coordinates and color
   logic                 p1_valid_ff, p1_valid_in;
   logic [COORD_W-1:0]   p1_px_ff, p1_py_ff;
   logic [COLOR_W-1:0]   p1_color_ff, color;
   logic                 p1_last_ff;

   // stage 2: row product
   logic                 p2_valid_ff, p2_valid_in;
   logic [COORD_W-1:0]   p2_px_ff, p2_py_ff;
   logic [COLOR_W-1:0]   p2_color_ff;
   logic                 p2_last_ff;
   logic [ADDR_W-1:0]    p2_prod_ff;
   logic [2*COORD_W-1:0] prod;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [PIX_W-1:0]     out_x_ff, out_y_ff;
   logic [ADDR_W-1:0]    out_addr_ff;
   logic [COLOR_W-1:0]   out_color_ff;
   logic                 out_last_ff;

   logic                 out_free;
   logic                 p2_free;
   logic                 p1_free;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign p2_free  = !p2_valid_ff || out_free;
   assign p1_free  = !p1_valid_ff || p2_free;

   // lowest pending cell first gives row-major order
   always_comb begin
      cur_cell = '0;
      for (int k = CELLS - 1; k >= 0; k--) begin
         if (left_ff[k]) begin
            cur_cell = CELL_W'(k);
         end
      end
   end

   assign cell_bit  = CELLS'(1) << cur_cell;
   assign tile_done = ((left_ff & ~cell_bit) == '0);
   assign advance   = cur_valid_ff && p1_free;
   assign load      = !cur_valid_ff || (advance && tile_done);
   assign pop_ready = load;

   always_comb begin
      if (desc_ff.wall_mask[cur_cell]) begin
         color = WALL_COLOR;
      end else if (desc_ff.fore_mask[cur_cell]) begin
         color = desc_ff.fore_color;
      end else begin
         color = desc_ff.back_color;
      end
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      left_in      = left_ff;
      if (advance) begin
         left_in = left_ff & ~cell_bit;
         if (tile_done) begin
            cur_valid_in = 1'b0;
         end
      end
      if (load && pop_valid) begin
         cur_valid_in = 1'b1;
         left_in      = pop_desc.emit_mask;
      end
   end

   assign p1_valid_in  = advance ? 1'b1 : (p2_free ? 1'b0 : p1_valid_ff);
   assign p2_valid_in  = (p1_valid_ff && p2_free) ? 1'b1 : (out_free ? 1'b0 : p2_valid_ff);
   assign out_valid_in = (p2_valid_ff && out_free) ? 1'b1
                       : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   assign prod         = p1_py_ff * cfg.row_stride;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         left_ff      <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         left_ff      <= left_in;
         p1_valid_ff  <= p1_valid_in;
         p2_valid_ff  <= p2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         desc_ff <= pop_desc;
      end
      if (advance) begin
         // in-frame coordinates are non-negative, so the low bits suffice
         p1_px_ff    <= desc_ff.origin_x + COORD_W'(cur_cell[1:0]);
         p1_py_ff    <= desc_ff.origin_y + COORD_W'(cur_cell[3:2]);
         p1_color_ff <= color;
         p1_last_ff  <= tile_done;
      end
      if (p1_valid_ff && p2_free) begin
         p2_px_ff    <= p1_px_ff;
         p2_py_ff    <= p1_py_ff;
         p2_color_ff <= p1_color_ff;
         p2_last_ff  <= p1_last_ff;
         p2_prod_ff  <= prod[ADDR_W-1:0];
      end
      if (p2_valid_ff && out_free) begin
         out_x_ff     <= p2_px_ff[PIX_W-1:0];
         out_y_ff     <= p2_py_ff[PIX_W-1:0];
         out_addr_ff  <= p2_prod_ff + ADDR_W'(p2_px_ff);
         out_color_ff <= p2_color_ff;
         out_last_ff  <= p2_last_ff;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pixel_x       = out_x_ff;
   assign rsp_chan.pixel_y       = out_y_ff;
   assign rsp_chan.pixel_address = out_addr_ff;
   assign rsp_chan.pixel_color   = out_color_ff;
   assign rsp_chan.last_pixel    = out_last_ff;

`ifndef SYNTH
   a_tile_has_pixels: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> left_ff != '0)
      else $error("active tile with empty pixel mask");

   a_p1_holds: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !p2_free |=> p1_valid_ff && $stable(p1_px_ff) && $stable(p1_last_ff))
      else $error("stage 1 lost data under stall");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking bench for shaped_tile_rasterizer: tile transfers in, pixel checks out.
// Depends on str_pkg and the str_channels interfaces; predicts every pixel locally.

module testbench;
   import str_pkg::*;

   localparam int MAX_DIM  = 4096;
   localparam int SETTLE   = 12;          // settle margin past the depth of the pixel pipeline
   localparam int HOLD_LEN = 400;         // long receiver hold-off, fills the tile queue

   // fill masks, bit k is cell k
   localparam logic [CELLS-1:0] SHAPE_BITS [16] = '{
      16'h0000, 16'hFFFF, 16'hF731, 16'h1133, 16'h88CC, 16'hFFEE, 16'hFF77, 16'h3333,
      16'h3100, 16'hCEFF, 16'h113F, 16'hEEC0, 16'hF600, 16'h0000, 16'h0000, 16'h0000
   };

   // cell index into the mask, per quarter turn and tile position
   localparam int ROTATION [4][16] = '{
      '{ 0,  1,  2,  3,  4,  5,  6,  7,  8,  9, 10, 11, 12, 13, 14, 15},
      '{12,  8,  4,  0, 13,  9,  5,  1, 14, 10,  6,  2, 15, 11,  7,  3},
      '{15, 14, 13, 12, 11, 10,  9,  8,  7,  6,  5,  4,  3,  2,  1,  0},
      '{ 3,  7, 11, 15,  2,  6, 10, 14,  1,  5,  9, 13,  0,  4,  8, 12}
   };

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COLOR_W-1:0] back_color;
      logic [COLOR_W-1:0] fore_color;
      logic [SHAPE_W-1:0] shape_code;
      logic [TURN_W-1:0]  turn;
      logic [WALL_W-1:0]  wall_flags;
   } tile_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_x;
      logic [PIX_W-1:0]   pixel_y;
      logic [ADDR_W-1:0]  pixel_address;
      logic [COLOR_W-1:0] pixel_color;
      logic               last_pixel;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   str_req_if req_if ();
   str_rsp_if rsp_if ();
   str_csr_if csr_if ();

   shaped_tile_rasterizer #(.MAX_DIM(MAX_DIM)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // tiles waiting for the driver, and pixels the frame buffer should see, oldest first
   tile_type  tile_queue [$];
   pixel_type pixel_queue [$];
   tile_type  tile_on_bus;
   pixel_type seen_pixel;
   pixel_type wanted_pixel;

   // local copy of the clip window and stride, already clamped to MAX_DIM
   int clip_w_model = MAX_DIM;
   int clip_h_model = MAX_DIM;
   int stride_model = MAX_DIM;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   logic hold_req = 1'b0;
   int hold_left = 0;
   int mismatch_count = 0;

   function automatic int clamp_dim(input logic [COORD_W-1:0] value);
      return (value > MAX_DIM) ? MAX_DIM : int'(value);
   endfunction

   // Expected pixel writes of one tile, row-major, appended to pixel_queue.
   function automatic void rasterize_tile(input tile_type t);
      int ox, oy, px, py, r, c;
      logic mask, wr, wall;
      logic [COLOR_W-1:0] color;
      pixel_type pix;
      pixel_type found [$];
      ox = $signed(t.origin_x);
      oy = $signed(t.origin_y);
      if (t.fore_color == '0 && t.back_color == '0) begin
         return;   // nothing at all, walls included
      end
      for (r = 0; r < 4; r++) begin
         for (c = 0; c < 4; c++) begin
            px = ox + c;
            py = oy + r;
            mask = SHAPE_BITS[t.shape_code][ROTATION[t.turn][4 * r + c]];
            wr = 1'b0;
            color = '0;
            if (t.fore_color == '0) begin
               wr = 1'b1;
               color = t.back_color;
            end else if (t.back_color != '0) begin
               wr = 1'b1;
               color = mask ? t.fore_color : t.back_color;
            end else if (mask) begin
               wr = 1'b1;
               color = t.fore_color;
            end
            wall = (t.wall_flags[WALL_WEST]  && c == 0) ||
                   (t.wall_flags[WALL_NORTH] && r == 0) ||
                   (t.wall_flags[WALL_EAST]  && c == 3) ||
                   (t.wall_flags[WALL_SOUTH] && r == 3) ||
                   (t.wall_flags[WALL_NESW]  && c == 3 - r) ||
                   (t.wall_flags[WALL_NWSE]  && c == r);
            if (wall) begin
               wr = 1'b1;
               color = WALL_COLOR;
            end
            if (wr && px >= 0 && px < clip_w_model && py >= 0 && py < clip_h_model) begin
               pix.pixel_x       = PIX_W'(px);
               pix.pixel_y       = PIX_W'(py);
               pix.pixel_address = ADDR_W'(py * stride_model + px);
               pix.pixel_color   = color;
               pix.last_pixel    = 1'b0;
               found.push_back(pix);
            end
         end
      end
      if (found.size() != 0) begin
         found[found.size() - 1].last_pixel = 1'b1;
      end
      foreach (found[i]) begin
         pixel_queue.push_back(found[i]);
      end
   endfunction

   function automatic tile_type make_tile(input int ox, input int oy,
                                          input logic [COLOR_W-1:0] back,
                                          input logic [COLOR_W-1:0] fore,
                                          input int shape, input int turn, input int walls);
      tile_type t;
      t.origin_x   = COORD_W'(ox);
      t.origin_y   = COORD_W'(oy);
      t.back_color = back;
      t.fore_color = fore;
      t.shape_code = SHAPE_W'(shape);
      t.turn       = TURN_W'(turn);
      t.wall_flags = WALL_W'(walls);
      return t;
   endfunction

   // Half the tiles land on or near the clip window so pixels come out;
   // the rest take the full origin range, every bit of it.
   function automatic tile_type random_tile();
      tile_type t;
      int sel;
      if ($urandom_range(1) == 0) begin
         t.origin_x = COORD_W'(int'($urandom_range(clip_w_model + 3)) - 4);
         t.origin_y = COORD_W'(int'($urandom_range(clip_h_model + 3)) - 4);
      end else begin
         t.origin_x = COORD_W'($urandom);
         t.origin_y = COORD_W'($urandom);
      end
      sel = $urandom_range(9);
      t.back_color = (sel < 2) ? '0 : (sel == 2) ? WALL_COLOR : COLOR_W'($urandom);
      sel = $urandom_range(9);
      t.fore_color = (sel < 3) ? '0 : (sel == 3) ? WALL_COLOR : COLOR_W'($urandom);
      t.shape_code = SHAPE_W'($urandom_range(15));
      t.turn       = TURN_W'($urandom_range(3));
      t.wall_flags = ($urandom_range(1) == 0) ? '0 : WALL_W'($urandom);
      return t;
   endfunction

   // Driver: one tile on the req channel at a time, random gaps between transfers.
   // Expected pixels are computed at the edge where the tile transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            rasterize_tile(tile_on_bus);
         end
         if (tile_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            tile_on_bus = tile_queue.pop_front();
            req_if.valid      <= 1'b1;
            req_if.origin_x   <= tile_on_bus.origin_x;
            req_if.origin_y   <= tile_on_bus.origin_y;
            req_if.back_color <= tile_on_bus.back_color;
            req_if.fore_color <= tile_on_bus.fore_color;
            req_if.shape_code <= tile_on_bus.shape_code;
            req_if.turn       <= tile_on_bus.turn;
            req_if.wall_flags <= tile_on_bus.wall_flags;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Hold-off counter: while it runs the receiver refuses every pixel.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_req) begin
         hold_left <= HOLD_LEN;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: every pixel transfer is checked against the oldest expected pixel.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_pixel.pixel_x       = rsp_if.pixel_x;
         seen_pixel.pixel_y       = rsp_if.pixel_y;
         seen_pixel.pixel_address = rsp_if.pixel_address;
         seen_pixel.pixel_color   = rsp_if.pixel_color;
         seen_pixel.last_pixel    = rsp_if.last_pixel;
         if (pixel_queue.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected pixel x=%0d y=%0d addr=%h color=%h last=%b",
                        seen_pixel.pixel_x, seen_pixel.pixel_y, seen_pixel.pixel_address,
                        seen_pixel.pixel_color, seen_pixel.last_pixel);
            end
            mismatch_count++;
         end else begin
            wanted_pixel = pixel_queue.pop_front();
            if (seen_pixel.pixel_x != wanted_pixel.pixel_x ||
                seen_pixel.pixel_y != wanted_pixel.pixel_y ||
                seen_pixel.pixel_address != wanted_pixel.pixel_address ||
                seen_pixel.pixel_color != wanted_pixel.pixel_color ||
                seen_pixel.last_pixel != wanted_pixel.last_pixel) begin
               if (mismatch_count < 10) begin
                  $display({"pixel mismatch: x %0d/%0d y %0d/%0d addr %h/%h",
                            " color %h/%h last %b/%b"},
                           wanted_pixel.pixel_x, seen_pixel.pixel_x,
                           wanted_pixel.pixel_y, seen_pixel.pixel_y,
                           wanted_pixel.pixel_address, seen_pixel.pixel_address,
                           wanted_pixel.pixel_color, seen_pixel.pixel_color,
                           wanted_pixel.last_pixel, seen_pixel.last_pixel);
               end
               mismatch_count++;
            end
         end
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= (hold_left == 0) && !hold_req && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Register write over the csr channel; the local copy follows on the transfer.
   task automatic write_reg(input csr_index_type idx, input logic [COORD_W-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_COL_LIMIT:   clip_w_model = clamp_dim(value);
         CSR_ROW_LIMIT:   clip_h_model = clamp_dim(value);
         CSR_ROW_STRIDE:  stride_model = clamp_dim(value);
         default: ;
      endcase
   endtask

   // Idle point: every tile transferred, every pixel seen, then a short settle so
   // tiles that write nothing are surely out of the pipe.
   task automatic drain();
      while (tile_queue.size() != 0 || req_if.valid) @(posedge clock);
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic run_phase(input logic [COORD_W-1:0] cw, input logic [COORD_W-1:0] ch,
                            input logic [COORD_W-1:0] stride, input int tiles,
                            input int tx_pct, input int rx_pct);
      write_reg(CSR_COL_LIMIT, cw);
      write_reg(CSR_ROW_LIMIT, ch);
      write_reg(CSR_ROW_STRIDE, stride);
      tx_idle_pct <= tx_pct;
      rx_idle_pct <= rx_pct;
      repeat (tiles) tile_queue.push_back(random_tile());
      drain();
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.origin_x   = '0;
      req_if.origin_y   = '0;
      req_if.back_color = '0;
      req_if.fore_color = '0;
      req_if.shape_code = '0;
      req_if.turn       = '0;
      req_if.wall_flags = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_COL_LIMIT;
      csr_if.data       = '0;
      tx_idle_pct       = 34;
      rx_idle_pct       = 73;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed tiles at the reset clip window.
      tile_queue.push_back(make_tile(10, 20, '0, '0, 1, 0, 63));          // both colors off
      tile_queue.push_back(make_tile(0, 0, 32'h1234_5678, '0, 3, 1, 0));  // background only
      for (int t = 0; t < 4; t++) begin                                     // every turn
         tile_queue.push_back(make_tile(40, 8, 32'hA5A5_A5A5, 32'h0000_0001, 2, t, 0));
      end
      tile_queue.push_back(make_tile(64, 64, '0, 32'hFFFF_FFFF, 5, 2, 0));  // fore over nothing
      tile_queue.push_back(make_tile(64, 64, '0, 32'hC0FF_EE00, 0, 0, 0));  // empty mask, no back
      tile_queue.push_back(make_tile(64, 64, '0, 32'h0000_0001, 13, 1, 0));
      tile_queue.push_back(make_tile(80, 64, '0, 32'h0000_0002, 14, 2, 6'h21)); // walls only
      tile_queue.push_back(make_tile(96, 64, 32'h0000_0003, 32'h7, 15, 3, 0));
      for (int k = 0; k < WALL_W; k++) begin                                // each wall alone
         tile_queue.push_back(make_tile(200, 300, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 11, 0, 1 << k));
      end
      tile_queue.push_back(make_tile(500, 7, 32'h0000_0010, 32'h0000_0020, 12, 1, 63));
      tile_queue.push_back(make_tile(-4096, -4096, 32'h1, 32'h2, 1, 0, 63)); // far off screen
      tile_queue.push_back(make_tile(4095, 4095, 32'h1, 32'h2, 4, 3, 63));   // one corner pixel
      tile_queue.push_back(make_tile(-2, -3, 32'h5, 32'h6, 6, 2, 6'h30));    // partly clipped
      tile_queue.push_back(make_tile(4093, 0, 32'h8, '0, 9, 0, 0));
      tile_queue.push_back(make_tile(0, 4093, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10, 3, 0));

      // Long receiver hold-off while tiles keep coming: the queue fills and req stalls.
      @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (20) tile_queue.push_back(random_tile());
      drain();

      // Register settings, extremes among them; idling swaps sides, then stops.
      run_phase(13'd1, 13'd1, 13'd0, 20, 34, 73);             // single pixel, zero stride
      run_phase(13'd0, 13'd4096, 13'd4096, 10, 34, 73);       // zero clip: nothing written
      run_phase(13'd8191, 13'd8191, 13'd8191, 20, 73, 34);    // all clamped to the maximum
      run_phase(13'd37, 13'd23, 13'd1, 20, 73, 34);
      run_phase(13'd4095, 13'd4095, 13'd4095, 20, 0, 0);
      run_phase(COORD_W'($urandom_range(1, 4096)), COORD_W'($urandom_range(1, 4096)),
                COORD_W'($urandom), 20, 0, 0);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit, far past the slowest correct run.
   initial begin
      #3000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
